// ===== hw/rtl/min_swaps_group_below_threshold_macros.svh =====
// Assertion macros for the checker file.
`ifndef MIN_SWAPS_GROUP_BELOW_THRESHOLD_MACROS_SVH
`define MIN_SWAPS_GROUP_BELOW_THRESHOLD_MACROS_SVH

// Condition in one cycle implies a consequence in the next; off during reset.
`define MSWP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same, but also checked across reset.
`define MSWP_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mswp_pkg.sv =====
package mswp_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int VALUE_W     = 32;
  localparam int SWAPS_W     = 11;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;        // store accepted element, or flag overflow
    logic scan_start;  // clear scan pointer and window sums
    logic scan_step;   // issue reads for one scan position, advance
    logic finish;      // load result register, clear sequence counters
  } cmd_t;

  typedef struct packed {
    logic scan_last;   // current scan position is the last stored element
    logic out_free;    // result register can take a new result
  } status_t;

endpackage

// ===== hw/rtl/min_swaps_group_below_threshold.sv =====
// A beat without tlast is taken one per cycle, back to back, while idle.
// A beat with tlast starts a scan over the N stored elements, one position per
// cycle; WAIT and DONE follow, and DONE loads the result register.
// Input stays closed from the tlast beat until DONE loads the result, which also
// waits while the previous result still waits for m_axis_tready.
// Reset (rst, synchronous, active high) clears counters, control state and the
// threshold (to 0); the flag store holds no reset and needs no clearing pass.
module min_swaps_group_below_threshold
  import mswp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // threshold register write
  input  logic                  cfg_wr_en,
  input  logic [VALUE_W-1:0]    cfg_wr_data,   // threshold, signed
  // element stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,  // [31:0] value, signed
  input  logic                  s_axis_tlast,  // final element of the sequence
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [10:0] min_swaps, [15:11] zero
  output logic                  m_axis_tuser   // [0] overflow
);

  cmd_t    cmd;
  status_t status;

  // Controller: take beats while idle, step the scan, hand off the result.
  mswp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  // Datapath: threshold compare, flag store, sliding window sum and minimum,
  // and the result register that lets the next sequence load while the
  // previous result waits for the sink.
  mswp_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tdata  (s_axis_tdata),
    .cmd           (cmd),
    .status        (status),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hw/rtl/mswp_ram.sv =====
module mswp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mswp_ctrl.sv =====
module mswp_ctrl
  import mswp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  input  logic    s_axis_tlast,
  output logic    s_axis_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load = 1'b1;
          if (s_axis_tlast) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_WAIT;
        end
      end
      // last read is in flight; its sum lands at the end of this cycle
      ST_WAIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mswp_dp.sv =====
module mswp_dp
  import mswp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [VALUE_W-1:0]    cfg_wr_data,
  input  logic [VALUE_W-1:0]    s_axis_tdata,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  m_axis_tready,
  output logic                  m_axis_tvalid,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int XW = (CW > SWAPS_W) ? CW : SWAPS_W;

  logic [VALUE_W-1:0] threshold;
  logic [CW-1:0]      elem_cnt;
  logic [CW-1:0]      small_cnt;
  logic               overflowed;
  logic [CW-1:0]      scan_pos;
  logic [CW-1:0]      win_cnt;
  logic [CW-1:0]      best;
  logic               rd_valid;
  logic               rd_fill;
  logic               rd_fill_last;
  logic               above;
  logic               full;
  logic               fill_now;
  logic [CW-1:0]      lead_pos;
  logic               wr_en;
  logic               flag_in;
  logic               flag_out;
  logic [CW-1:0]      win_next;
  logic [XW-1:0]      best_x;
  logic               out_valid;
  logic [SWAPS_W-1:0] out_swaps;
  logic               out_ovf;

  assign above    = $signed(s_axis_tdata) > $signed(threshold);
  assign full     = (elem_cnt == CW'(MAX_LEN));
  assign wr_en    = cmd.load && !full;
  assign fill_now = (scan_pos < small_cnt);
  assign lead_pos = scan_pos - small_cnt;

  // two copies of the flag store: one read at the window head, one at its tail
  mswp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_ram_in (
    .clk   (clk),
    .we    (wr_en),
    .waddr (elem_cnt[AW-1:0]),
    .wdata (above),
    .raddr (scan_pos[AW-1:0]),
    .rdata (flag_in)
  );

  mswp_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_ram_out (
    .clk   (clk),
    .we    (wr_en),
    .waddr (elem_cnt[AW-1:0]),
    .wdata (above),
    .raddr (lead_pos[AW-1:0]),
    .rdata (flag_out)
  );

  always_comb begin
    if (rd_fill) begin
      win_next = win_cnt + CW'(flag_in);
    end else begin
      win_next = win_cnt + CW'(flag_in) - CW'(flag_out);
    end
  end

  assign status.scan_last = (scan_pos == elem_cnt - CW'(1));
  assign status.out_free  = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt   <= '0;
      small_cnt  <= '0;
      overflowed <= 1'b0;
    end else if (cmd.finish) begin
      elem_cnt   <= '0;
      small_cnt  <= '0;
      overflowed <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflowed <= 1'b1;
      end else begin
        elem_cnt <= elem_cnt + CW'(1);
        if (!above) begin
          small_cnt <= small_cnt + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos     <= '0;
      win_cnt      <= '0;
      best         <= '0;
      rd_valid     <= 1'b0;
      rd_fill      <= 1'b0;
      rd_fill_last <= 1'b0;
    end else begin
      rd_valid     <= cmd.scan_step;
      rd_fill      <= fill_now;
      rd_fill_last <= fill_now && (scan_pos + CW'(1) == small_cnt);
      if (cmd.scan_start) begin
        scan_pos <= '0;
        win_cnt  <= '0;
        best     <= '0;
      end else begin
        if (cmd.scan_step) begin
          scan_pos <= scan_pos + CW'(1);
        end
        if (rd_valid) begin
          win_cnt <= win_next;
          if (rd_fill_last) begin
            best <= win_next;
          end else if (!rd_fill && (win_next < best)) begin
            best <= win_next;
          end
        end
      end
    end
  end

  assign best_x = XW'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_swaps <= best_x[SWAPS_W-1:0];
      out_ovf   <= overflowed;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_W'(out_swaps);
  assign m_axis_tuser  = out_ovf;

endmodule

// ===== hw/rtl/mswp_checker.sv =====
`include "min_swaps_group_below_threshold_macros.svh"

module mswp_checker
  import mswp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // a stalled result beat stays offered
  `MSWP_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")

  // and keeps its payload
  `MSWP_ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result payload changed while stalled")

  // the final beat of a sequence starts the scan, so input closes next cycle
  `MSWP_ASSERT_NEXT(a_last_closes, clk, rst, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input still open after final beat")

  // reset leaves no result pending
  `MSWP_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !m_axis_tvalid, "result valid right after reset")

endmodule

bind min_swaps_group_below_threshold mswp_checker u_mswp_checker (.*);
